/* rtl/core/rmfh_pkg.sv */
// ----------------------------------------------------------------------------
// rmfh_pkg: shared types and constants of the recursive mutex
// Status codes, queue sizing and the control structs between the
// sequencer and the wait queue chain.
// ----------------------------------------------------------------------------
package rmfh_pkg;

   // Sizing of the wait queue and of one release-all run
   localparam int QUEUE_DEPTH  = 16;
   localparam int MAX_RESULTS  = 16;
   localparam int TASK_W       = 8;
   localparam int DEPTH_W      = 16;
   localparam int IDX_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
   localparam int RUN_W        = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

   localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};

   // Operation codes
   typedef enum logic [1:0] {
      KIND_WAIT    = 2'd0,
      KIND_SIGNAL  = 2'd1,
      KIND_RELEASE = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   // Result status codes
   typedef enum logic [3:0] {
      ST_ACQUIRED   = 4'd0,
      ST_NESTED     = 4'd1,
      ST_BLOCKED    = 4'd2,
      ST_DEPTH_DOWN = 4'd3,
      ST_FREED      = 4'd4,
      ST_HANDED     = 4'd5,
      ST_NOT_OWNER  = 4'd6,
      ST_NOT_HELD   = 4'd7,
      ST_WOKEN      = 4'd8,
      ST_Q_EMPTY    = 4'd9,
      ST_NEST_OVF   = 4'd10,
      ST_Q_FULL     = 4'd11
   } status_type;

   // Commands from the sequencer to the queue
   typedef struct packed {
      logic              push;
      logic              pop;
      logic [TASK_W-1:0] push_task;
   } q_ctl_type;

   // Status from the queue back to the sequencer
   typedef struct packed {
      logic [CNT_W-1:0]  count;
      logic [TASK_W-1:0] head;
   } q_stat_type;

endpackage

/* rtl/core/recursive_mutex_fifo_handoff.sv */
// ----------------------------------------------------------------------------
// recursive_mutex_fifo_handoff: recursive mutex with FIFO wait queue
// Grants, nests, queues and hands over ownership; release-all wakes the
// queued waiters one result per cycle while the rsp side takes them.
//
//   channel | direction | tdata                               | tuser   | tlast
//   req     | in        | task_id                             | kind    | -
//   rsp     | out       | woken,to_head,sched,depth,owner     | status  | run_last
//
// Wait and signal each give one result, which sits in the output
// register; the next item is taken as soon as that register frees.
// Release-all enters the drain with no result, then wakes one waiter per
// free output slot (up to MAX_RESULTS), paced by the cell chain's single pop.
// Reset is synchronous and clears owner, depth and fill count; queue cells
// keep their contents. A stalled rsp side holds the result and blocks req.
// ----------------------------------------------------------------------------
module recursive_mutex_fifo_handoff
   import rmfh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] task_id
   input  logic [1:0]  req_tuser,   // [1:0] kind
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] woken_task, [8] wake_to_head,
                                    // [9] call_scheduler, [25:10] depth_now,
                                    // [33:26] owner_now, [39:34] zero
   output logic [3:0]  rsp_tuser,   // [3:0] status
   output logic        rsp_tlast    // run_last
);

   typedef enum logic [1:0] {
      SEQ_IDLE  = 2'b01,
      SEQ_DRAIN = 2'b10
   } seq_type;

   seq_type            seq_ff, seq_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [TASK_W-1:0]  owner_ff, owner_in;
   logic [RUN_W-1:0]   run_ff, run_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // output payload registers
   status_type         status_ff, status_in;
   logic [TASK_W-1:0]  woken_ff, woken_in;
   logic               to_head_ff, to_head_in;
   logic               sched_ff, sched_in;
   logic [DEPTH_W-1:0] depth_out_ff, depth_out_in;
   logic [TASK_W-1:0]  owner_out_ff, owner_out_in;
   logic               last_ff, last_in;
   logic               load_rsp;

   q_ctl_type          q_ctl;
   q_stat_type         q_stat;

   logic               out_free;
   logic               accept;
   kind_type           kind;
   logic [TASK_W-1:0]  req_task;
   logic               q_full;
   logic               q_empty;
   logic               run_end;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (seq_ff == SEQ_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign kind       = kind_type'(req_tuser);
   assign req_task   = req_tdata;
   assign q_full     = (q_stat.count == CNT_W'(QUEUE_DEPTH));
   assign q_empty    = (q_stat.count == '0);
   assign run_end    = (q_stat.count == CNT_W'(1)) ||
                       (run_ff == RUN_W'(MAX_RESULTS - 1));

   // Sequence each transfer and each drain step
   always_comb begin
      seq_in        = seq_ff;
      depth_in      = depth_ff;
      owner_in      = owner_ff;
      run_in        = run_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      load_rsp      = 1'b0;
      status_in     = status_ff;
      woken_in      = '0;
      to_head_in    = 1'b0;
      sched_in      = 1'b0;
      last_in       = 1'b1;
      q_ctl         = '0;
      q_ctl.push_task = req_task;

      unique case (seq_ff)
         SEQ_IDLE: begin
            if (accept) begin
               unique case (kind)
                  KIND_WAIT: begin
                     load_rsp = 1'b1;
                     if (depth_ff == '0) begin
                        depth_in  = DEPTH_W'(1);
                        owner_in  = req_task;
                        status_in = ST_ACQUIRED;
                     end else if (owner_ff == req_task) begin
                        if (depth_ff == DEPTH_MAX) begin
                           status_in = ST_NEST_OVF;
                        end else begin
                           depth_in  = depth_ff + DEPTH_W'(1);
                           status_in = ST_NESTED;
                        end
                     end else if (q_full) begin
                        status_in = ST_Q_FULL;
                     end else begin
                        q_ctl.push = 1'b1;
                        status_in  = ST_BLOCKED;
                        sched_in   = 1'b1;
                     end
                  end
                  KIND_SIGNAL: begin
                     load_rsp = 1'b1;
                     if (depth_ff == '0) begin
                        status_in = ST_NOT_HELD;
                     end else if (owner_ff != req_task) begin
                        status_in = ST_NOT_OWNER;
                     end else if (depth_ff != DEPTH_W'(1)) begin
                        depth_in  = depth_ff - DEPTH_W'(1);
                        status_in = ST_DEPTH_DOWN;
                     end else if (q_empty) begin
                        depth_in  = '0;
                        status_in = ST_FREED;
                     end else begin
                        q_ctl.pop  = 1'b1;
                        owner_in   = q_stat.head;
                        status_in  = ST_HANDED;
                        woken_in   = q_stat.head;
                        to_head_in = 1'b1;
                        sched_in   = 1'b1;
                     end
                  end
                  KIND_RELEASE: begin
                     if (q_empty) begin
                        load_rsp  = 1'b1;
                        status_in = ST_Q_EMPTY;
                     end else begin
                        seq_in = SEQ_DRAIN;
                        run_in = '0;
                     end
                  end
                  KIND_NONE: begin
                     // drop the item, no result
                  end
                  default: begin
                  end
               endcase
            end
         end
         SEQ_DRAIN: begin
            // Wake the head waiter each cycle the output can take it
            if (out_free) begin
               load_rsp   = 1'b1;
               q_ctl.pop  = 1'b1;
               status_in  = ST_WOKEN;
               woken_in   = q_stat.head;
               last_in    = run_end;
               run_in     = run_ff + RUN_W'(1);
               if (run_end) begin
                  seq_in = SEQ_IDLE;
               end
            end
         end
         default: begin
            seq_in = SEQ_IDLE;
         end
      endcase

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end
      depth_out_in = depth_in;
      owner_out_in = (depth_in != '0) ? owner_in : '0;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SEQ_IDLE;
         depth_ff     <= '0;
         owner_ff     <= '0;
         run_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         depth_ff     <= depth_in;
         owner_ff     <= owner_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload: load with each new result, hold while stalled
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         status_ff    <= status_in;
         woken_ff     <= woken_in;
         to_head_ff   <= to_head_in;
         sched_ff     <= sched_in;
         depth_out_ff <= depth_out_in;
         owner_out_ff <= owner_out_in;
         last_ff      <= last_in;
      end
   end

   rmfh_queue u_queue (
      .clock (clock),
      .reset (reset),
      .ctl   (q_ctl),
      .stat  (q_stat)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, owner_out_ff, depth_out_ff, sched_ff, to_head_ff, woken_ff};
   assign rsp_tuser  = status_ff;
   assign rsp_tlast  = last_ff;

endmodule

/* rtl/core/rmfh_cell.sv */
// ----------------------------------------------------------------------------
// rmfh_cell: one slot of the wait queue chain
// Holds one waiting task; loads a new task or takes its upper neighbor's
// entry when the queue advances.
// ----------------------------------------------------------------------------
module rmfh_cell
   import rmfh_pkg::*;
(
   input  logic              clock,
   input  logic              load,
   input  logic [TASK_W-1:0] load_task,
   input  logic              shift,
   input  logic [TASK_W-1:0] next_task,
   output logic [TASK_W-1:0] task_out
);

   logic [TASK_W-1:0] task_ff;
   logic [TASK_W-1:0] task_in;

   // Pick new entry: load beats shift, otherwise hold
   always_comb begin
      priority if (load) begin
         task_in = load_task;
      end else if (shift) begin
         task_in = next_task;
      end else begin
         task_in = task_ff;
      end
   end

   always_ff @(posedge clock) begin
      task_ff <= task_in;
   end

   assign task_out = task_ff;

endmodule

/* rtl/core/rmfh_queue.sv */
// ----------------------------------------------------------------------------
// rmfh_queue: FIFO wait queue built as a chain of cells
// Cell 0 is the head. A push writes the cell at the fill count; a pop
// moves every entry one cell toward the head.
// ----------------------------------------------------------------------------
module rmfh_queue
   import rmfh_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  q_ctl_type  ctl,
   output q_stat_type stat
);

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [TASK_W-1:0] cell_task [QUEUE_DEPTH];

   // Track fill level
   always_comb begin
      count_in = count_ff;
      if (ctl.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Build the chain; the top cell feeds itself back
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic [TASK_W-1:0] upper;
      if (i == QUEUE_DEPTH - 1) begin : g_top
         assign upper = cell_task[i];
      end else begin : g_mid
         assign upper = cell_task[i+1];
      end

      rmfh_cell u_cell (
         .clock     (clock),
         .load      (ctl.push && (count_ff == CNT_W'(i))),
         .load_task (ctl.push_task),
         .shift     (ctl.pop),
         .next_task (upper),
         .task_out  (cell_task[i])
      );
   end

   assign stat.count = count_ff;
   assign stat.head  = cell_task[0];

endmodule

/* verif/mutex_outcome_check.sv */
// ----------------------------------------------------------------------------
// mutex_outcome_check: result checker for the recursive mutex
// Watches both stream channels. Every accepted request is run through a
// local model of the mutex (owner, depth, FIFO wait queue), and the results
// it should cause are queued in order. Every accepted result is compared
// field by field with the oldest queued one. The mismatch count and the
// number of results still awaited go back to the testbench top.
// ----------------------------------------------------------------------------
module mutex_outcome_check
   import rmfh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] task_id
   input  logic [1:0]  req_tuser,   // [1:0] kind
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // [7:0] woken_task, [8] wake_to_head,
                                    // [9] call_scheduler, [25:10] depth_now,
                                    // [33:26] owner_now, [39:34] zero
   input  logic [3:0]  rsp_tuser,   // [3:0] status
   input  logic        rsp_tlast,   // run_last
   output int          mismatches,
   output int          outstanding
);

   // One result of the mutex as the channel carries it
   typedef struct {
      status_type         status;
      logic [TASK_W-1:0]  woken;
      logic               to_head;
      logic               sched;
      logic [DEPTH_W-1:0] depth;
      logic [TASK_W-1:0]  owner;
      logic               last;
   } outcome_type;

   // Mutex state as seen by the model
   logic [DEPTH_W-1:0] held_depth = '0;
   logic [TASK_W-1:0]  holder     = '0;
   logic [TASK_W-1:0]  waiters [QUEUE_DEPTH];
   logic [IDX_W-1:0]   wq_head    = '0;
   logic [IDX_W-1:0]   wq_tail    = '0;
   logic [CNT_W-1:0]   wq_count   = '0;

   outcome_type awaited [$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   // Print one line per mismatch and count it
   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   // Queue one result; depth and owner are taken after the state update
   task automatic note_outcome(input status_type status, input logic [TASK_W-1:0] woken,
                               input logic to_head, input logic sched, input logic last);
      outcome_type o;
      o.status  = status;
      o.woken   = woken;
      o.to_head = to_head;
      o.sched   = sched;
      o.depth   = held_depth;
      o.owner   = (held_depth != '0) ? holder : '0;
      o.last    = last;
      awaited.push_back(o);
   endtask

   // Take the oldest waiter off the queue
   task automatic pop_waiter(output logic [TASK_W-1:0] t);
      t        = waiters[wq_head];
      wq_head  = wq_head + 1'b1;
      wq_count = wq_count - 1'b1;
   endtask

   // Advance the mutex by one request and note what it causes
   task automatic apply_request(input kind_type kind, input logic [TASK_W-1:0] task_id);
      logic [TASK_W-1:0] t;
      int                n;
      // task ids are reduced modulo 256, which the 8-bit field already is
      case (kind)
         KIND_WAIT: begin
            if (held_depth == '0) begin
               held_depth = DEPTH_W'(1);
               holder     = task_id;
               note_outcome(ST_ACQUIRED, '0, 1'b0, 1'b0, 1'b1);
            end else if (holder == task_id) begin
               if (held_depth == DEPTH_MAX) begin
                  note_outcome(ST_NEST_OVF, '0, 1'b0, 1'b0, 1'b1);
               end else begin
                  held_depth = held_depth + 1'b1;
                  note_outcome(ST_NESTED, '0, 1'b0, 1'b0, 1'b1);
               end
            end else if (wq_count >= QUEUE_DEPTH) begin
               note_outcome(ST_Q_FULL, '0, 1'b0, 1'b0, 1'b1);
            end else begin
               waiters[wq_tail] = task_id;
               wq_tail  = wq_tail + 1'b1;
               wq_count = wq_count + 1'b1;
               note_outcome(ST_BLOCKED, '0, 1'b0, 1'b1, 1'b1);
            end
         end
         KIND_SIGNAL: begin
            if (held_depth == '0) begin
               note_outcome(ST_NOT_HELD, '0, 1'b0, 1'b0, 1'b1);
            end else if (holder != task_id) begin
               note_outcome(ST_NOT_OWNER, '0, 1'b0, 1'b0, 1'b1);
            end else if (held_depth > 1) begin
               held_depth = held_depth - 1'b1;
               note_outcome(ST_DEPTH_DOWN, '0, 1'b0, 1'b0, 1'b1);
            end else if (wq_count == '0) begin
               held_depth = '0;
               note_outcome(ST_FREED, '0, 1'b0, 1'b0, 1'b1);
            end else begin
               // hand ownership straight to the queue head
               pop_waiter(t);
               holder     = t;
               held_depth = DEPTH_W'(1);
               note_outcome(ST_HANDED, t, 1'b1, 1'b1, 1'b1);
            end
         end
         KIND_RELEASE: begin
            if (wq_count == '0) begin
               note_outcome(ST_Q_EMPTY, '0, 1'b0, 1'b0, 1'b1);
            end else begin
               // wake waiters in order, at most one run's worth
               n = 0;
               while (wq_count > 0 && n < MAX_RESULTS) begin
                  pop_waiter(t);
                  note_outcome(ST_WOKEN, t, 1'b0, 1'b0,
                               (wq_count == '0) || (n + 1 == MAX_RESULTS));
                  n++;
               end
            end
         end
         default: begin
            // unused kind: no result, no state change
         end
      endcase
   endtask

   task automatic compare_field(input string name, input logic [DEPTH_W-1:0] got,
                                input logic [DEPTH_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
   endtask

   // Compare one transfer on the result channel with the oldest expectation
   task automatic check_outcome();
      outcome_type w;
      if (awaited.size() == 0) begin
         report_mismatch($sformatf("result with status %0d arrived with none awaited",
                                   rsp_tuser));
         return;
      end
      w = awaited.pop_front();
      compare_field("status", DEPTH_W'(rsp_tuser), DEPTH_W'(w.status));
      compare_field("woken_task", DEPTH_W'(rsp_tdata[7:0]), DEPTH_W'(w.woken));
      compare_field("wake_to_head", DEPTH_W'(rsp_tdata[8]), DEPTH_W'(w.to_head));
      compare_field("call_scheduler", DEPTH_W'(rsp_tdata[9]), DEPTH_W'(w.sched));
      compare_field("depth_now", rsp_tdata[25:10], w.depth);
      compare_field("owner_now", DEPTH_W'(rsp_tdata[33:26]), DEPTH_W'(w.owner));
      compare_field("run_last", DEPTH_W'(rsp_tlast), DEPTH_W'(w.last));
   endtask

   // Check results before predicting, so a stray result never meets a fresh entry
   always @(posedge clock) begin
      if (reset) begin
         held_depth = '0;
         holder     = '0;
         wq_head    = '0;
         wq_tail    = '0;
         wq_count   = '0;
         awaited.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_outcome();
         if (req_tvalid && req_tready) apply_request(kind_type'(req_tuser), req_tdata);
      end
      outstanding = awaited.size();
   end

endmodule

/* verif/recursive_mutex_fifo_handoff_test.sv */
// ----------------------------------------------------------------------------
// recursive_mutex_fifo_handoff_test: testbench top for the recursive mutex
// Drives lock requests with random gaps and a randomly stalling result side,
// beside a checker that predicts and compares every result. A directed part
// covers the corner cases, a short nesting run hands the mutex over, and a
// random part exercises ownership churn, hand-over and release-all.
// ----------------------------------------------------------------------------
module recursive_mutex_fifo_handoff_test;
   import rmfh_pkg::*;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        rsp_tlast;

   int          mismatches;
   int          outstanding;

   // Stimulus controls shared with the result side
   logic        quiet        = 1'b0;
   logic        hold_pending = 1'b0;

   recursive_mutex_fifo_handoff dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   mutex_outcome_check outcome_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always #1 clock = ~clock;

   // Give up on a hung run
   initial begin
      #4000000;
      $display("Mismatches found");
      $finish;
   end

   // Offer one request after a random gap and hold it until the transfer
   task automatic offer_request(input kind_type kind, input logic [7:0] task_id);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= task_id;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Result side: random stall before each transfer, one long hold on request
   initial begin : rsp_side
      int gap;
      while (reset) @(posedge clock);
      forever begin
         if (hold_pending) begin
            hold_pending <= 1'b0;
            gap = 100;
         end else if (quiet) begin
            gap = 0;
         end else begin
            gap = $urandom_range(0, 12);
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // Request side and verdict
   initial begin : req_side
      logic [7:0] pool [4];
      kind_type   kind;
      logic [7:0] task_id;
      int         pick;
      int         counted;
      logic       pressed;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Corner cases: free mutex, empty queue, unused kind, nesting, foreign signal
      offer_request(KIND_SIGNAL, 8'd0);
      offer_request(KIND_RELEASE, 8'd0);
      offer_request(KIND_NONE, 8'h5A);
      offer_request(KIND_WAIT, 8'd255);
      offer_request(KIND_WAIT, 8'd255);
      offer_request(KIND_SIGNAL, 8'd0);
      offer_request(KIND_SIGNAL, 8'd255);
      // Fill the queue, with one task queued twice, then overflow it
      for (int i = 0; i < 15; i++) offer_request(KIND_WAIT, 8'(i));
      offer_request(KIND_WAIT, 8'd7);
      offer_request(KIND_WAIT, 8'd128);
      // Hand over to the head, then wake everyone left
      offer_request(KIND_SIGNAL, 8'd255);
      offer_request(KIND_RELEASE, 8'd200);

      // Nest once, queue a waiter, unwind and hand over, with no idling
      quiet = 1'b1;
      offer_request(KIND_WAIT, 8'd0);
      offer_request(KIND_WAIT, 8'd170);
      offer_request(KIND_SIGNAL, 8'd0);
      offer_request(KIND_SIGNAL, 8'd0);
      quiet = 1'b0;

      // Random churn among a few tasks; the current owner is always one of them
      pool[0] = 8'd170;
      for (int i = 1; i < 4; i++) pool[i] = 8'($urandom_range(0, 255));
      counted = 0;
      pressed = 1'b0;
      while (counted < 140) begin
         if (counted == 60 && !pressed) begin
            hold_pending <= 1'b1;
            pressed = 1'b1;
         end
         quiet = (counted >= 110 && counted < 135);
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            kind    = KIND_WAIT;
            task_id = pool[$urandom_range(0, 3)];
         end else if (pick < 85) begin
            kind    = KIND_SIGNAL;
            task_id = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                  : pool[$urandom_range(0, 3)];
         end else if (pick < 95) begin
            kind    = KIND_RELEASE;
            task_id = 8'($urandom_range(0, 255));
         end else begin
            kind    = KIND_NONE;
            task_id = 8'($urandom_range(0, 255));
         end
         offer_request(kind, task_id);
         if (kind != KIND_NONE) counted++;
      end
      quiet = 1'b0;
      req_tvalid <= 1'b0;

      // Drain remaining results, then allow for trailing latency
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/rmfh_pkg.sv
rtl/core/rmfh_cell.sv
rtl/core/rmfh_queue.sv
rtl/core/recursive_mutex_fifo_handoff.sv
verif/mutex_outcome_check.sv
verif/recursive_mutex_fifo_handoff_test.sv
